// ===== sv/uart_rx_fifo_with_reply_match_top_assert.svh =====
// Assertion macros used by the checker of the receive buffer.
`ifndef UART_RX_FIFO_WITH_REPLY_MATCH_TOP_ASSERT_SVH
`define UART_RX_FIFO_WITH_REPLY_MATCH_TOP_ASSERT_SVH

// Clocked property, switched off while reset is asserted.
`define URX_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked property that is also checked during reset.
`define URX_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/uartrx_pkg.sv =====
`default_nettype none

package uartrx_pkg;

  localparam int FIFO_DEPTH_DEF = 64;

  // Request codes carried by in_req_type.
  localparam logic [1:0] REQ_RX      = 2'd0;
  localparam logic [1:0] REQ_READ    = 2'd1;
  localparam logic [1:0] REQ_CLR_OK  = 2'd2;
  localparam logic [1:0] REQ_CLR_ERR = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_OK_LEN  = 1'b0;
  localparam logic CFG_ERR_LEN = 1'b1;

  localparam logic [2:0] OK_LEN_RST  = 3'd3;
  localparam logic [2:0] ERR_LEN_RST = 3'd5;

  localparam logic [2:0] OK_TOKEN_LEN  = 3'd4;
  localparam logic [2:0] ERR_TOKEN_LEN = 3'd7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load;
  } ctrl_cmd_t;

  // Characters of "[OK]".
  function automatic logic [7:0] ok_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h5B;
      3'd1:    c = 8'h4F;
      3'd2:    c = 8'h4B;
      3'd3:    c = 8'h5D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Characters of "[ERROR]".
  function automatic logic [7:0] err_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h5B;
      3'd1:    c = 8'h45;
      3'd2:    c = 8'h52;
      3'd3:    c = 8'h52;
      3'd4:    c = 8'h4F;
      3'd5:    c = 8'h52;
      3'd6:    c = 8'h5D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // A length of zero acts as one, anything above the token length as the length.
  function automatic logic [2:0] clamp_len(input logic [2:0] v, input logic [2:0] maxv);
    logic [2:0] r;
    if (v == 3'd0) begin
      r = 3'd1;
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/uartrx_ctrl.sv =====
`default_nettype none

module uartrx_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output uartrx_pkg::ctrl_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  // New requests are taken when nothing is pending or the pending result leaves now.
  assign in_stall  = !rst_n || (state_r == ST_LOAD) || ((state_r == ST_HOLD) && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = (state_r == ST_HOLD);

  assign cmd.accept = accept;
  assign cmd.load   = (state_r == ST_LOAD);

  always_comb begin
    unique case (state_r)
      ST_IDLE: begin
        state_nxt = accept ? ST_LOAD : ST_IDLE;
      end
      ST_LOAD: begin
        state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (!out_stall) begin
          state_nxt = accept ? ST_LOAD : ST_IDLE;
        end else begin
          state_nxt = ST_HOLD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/uartrx_dp.sv =====
`default_nettype none

module uartrx_dp #(
  parameter int FIFO_DEPTH = uartrx_pkg::FIFO_DEPTH_DEF,
  localparam int PTR_W = $clog2(FIFO_DEPTH),
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire uartrx_pkg::ctrl_cmd_t cmd,
  input  wire logic [1:0]            req_type,
  input  wire logic [7:0]            rx_byte,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [2:0]            cfg_data,
  output logic [7:0]                 read_data,
  output logic                       read_valid,
  output logic [CNT_W-1:0]           fill_count,
  output logic                       ok_seen,
  output logic                       error_seen,
  output logic                       overflow
);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

  logic [7:0]       mem [FIFO_DEPTH];
  logic [7:0]       rd_data_r;
  logic             rvalid_r;

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]       ok_prog_r, ok_prog_nxt;
  logic [2:0]       err_prog_r, err_prog_nxt;
  logic             ok_flag_r, ok_flag_nxt;
  logic             err_flag_r, err_flag_nxt;
  logic             ovf_flag_r, ovf_flag_nxt;
  logic [2:0]       ok_len_r;
  logic [2:0]       err_len_r;

  logic             is_rx;
  logic             is_read;
  logic             full;
  logic             empty;
  logic             wr_en;
  logic             rd_en;
  logic [2:0]       ok_step;
  logic [2:0]       err_step;

  assign is_rx   = cmd.accept && (req_type == uartrx_pkg::REQ_RX);
  assign is_read = cmd.accept && (req_type == uartrx_pkg::REQ_READ);
  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign wr_en   = is_rx && !full;
  assign rd_en   = is_read && !empty;

  // Prefix matchers: advance on the next expected character, otherwise restart at zero.
  always_comb begin
    if ((ok_prog_r < uartrx_pkg::OK_TOKEN_LEN) && (uartrx_pkg::ok_char(ok_prog_r) == rx_byte)) begin
      ok_step = ok_prog_r + 3'd1;
    end else begin
      ok_step = 3'd0;
    end
    if ((err_prog_r < uartrx_pkg::ERR_TOKEN_LEN) &&
        (uartrx_pkg::err_char(err_prog_r) == rx_byte)) begin
      err_step = err_prog_r + 3'd1;
    end else begin
      err_step = 3'd0;
    end
  end

  always_comb begin
    wr_ptr_nxt   = wr_ptr_r;
    rd_ptr_nxt   = rd_ptr_r;
    cnt_nxt      = cnt_r;
    ok_prog_nxt  = ok_prog_r;
    err_prog_nxt = err_prog_r;
    ok_flag_nxt  = ok_flag_r;
    err_flag_nxt = err_flag_r;
    ovf_flag_nxt = ovf_flag_r;
    if (cmd.accept) begin
      unique case (req_type)
        uartrx_pkg::REQ_RX: begin
          if (full) begin
            ovf_flag_nxt = 1'b1;
          end else begin
            wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
            cnt_nxt    = cnt_r + CNT_W'(1);
          end
          ok_prog_nxt  = ok_step;
          err_prog_nxt = err_step;
          if (ok_step >= uartrx_pkg::clamp_len(ok_len_r, uartrx_pkg::OK_TOKEN_LEN)) begin
            ok_flag_nxt = 1'b1;
          end
          if (err_step >= uartrx_pkg::clamp_len(err_len_r, uartrx_pkg::ERR_TOKEN_LEN)) begin
            err_flag_nxt = 1'b1;
          end
        end
        uartrx_pkg::REQ_READ: begin
          if (!empty) begin
            rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
            cnt_nxt    = cnt_r - CNT_W'(1);
          end
        end
        uartrx_pkg::REQ_CLR_OK: begin
          ok_flag_nxt = 1'b0;
          wr_ptr_nxt  = '0;
          rd_ptr_nxt  = '0;
          cnt_nxt     = '0;
        end
        uartrx_pkg::REQ_CLR_ERR: begin
          err_flag_nxt = 1'b0;
        end
        default: begin
          err_flag_nxt = err_flag_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      cnt_r      <= '0;
      ok_prog_r  <= 3'd0;
      err_prog_r <= 3'd0;
      ok_flag_r  <= 1'b0;
      err_flag_r <= 1'b0;
      ovf_flag_r <= 1'b0;
      ok_len_r   <= uartrx_pkg::OK_LEN_RST;
      err_len_r  <= uartrx_pkg::ERR_LEN_RST;
    end else begin
      wr_ptr_r   <= wr_ptr_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      cnt_r      <= cnt_nxt;
      ok_prog_r  <= ok_prog_nxt;
      err_prog_r <= err_prog_nxt;
      ok_flag_r  <= ok_flag_nxt;
      err_flag_r <= err_flag_nxt;
      ovf_flag_r <= ovf_flag_nxt;
      if (cfg_we) begin
        if (cfg_index == uartrx_pkg::CFG_OK_LEN) begin
          ok_len_r <= cfg_data;
        end else begin
          err_len_r <= cfg_data;
        end
      end
    end
  end

  // Byte store with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= rx_byte;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_ptr_r];
    end
    if (cmd.accept) begin
      rvalid_r <= rd_en;
    end
  end

  // Result register, filled in the cycle after the request is accepted, once the read data has landed.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      read_data  <= rvalid_r ? rd_data_r : 8'h00;
      read_valid <= rvalid_r;
      fill_count <= cnt_r;
      ok_seen    <= ok_flag_r;
      error_seen <= err_flag_r;
      overflow   <= ovf_flag_r;
    end
  end

endmodule

`default_nettype wire

// ===== sv/uart_rx_fifo_with_reply_match_top.sv =====
// Receive-side UART byte buffer with "[OK]" and "[ERROR]" reply detection.
// Input channel (in_valid / in_stall) carries one request per beat: a received
// byte, a read of the oldest stored byte, a clear of the ok flag that also
// empties the buffer, or a clear of the error flag. Every request yields
// exactly one result beat on the output channel (out_valid / out_stall) that
// shows the popped byte, the fill level and the three sticky flags as they
// stand after the request.
// The request is applied at its accept edge, the byte store read data is
// registered at that edge, and the result register loads on the following
// edge. The block stalls its input while the result register loads.
// A stalled result holds steady. While it waits the block stalls its input,
// and the next request is taken on the same edge the waiting result leaves.
// Reset (synchronous, active low) empties the buffer, clears matcher progress
// and all flags, and restores the match lengths to 3 and 5. The input stall
// stays high and the configuration port stays not-ready while reset is held.
// The configuration port writes a match length at any time outside reset;
// lengths should only change while no request is in flight.
`default_nettype none

module uart_rx_fifo_with_reply_match_top #(
  parameter int FIFO_DEPTH = uartrx_pkg::FIFO_DEPTH_DEF,
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       in_req_type,
  input  wire logic [7:0]       in_rx_byte,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [7:0]            out_read_data,
  output logic                  out_read_valid,
  output logic [CNT_W-1:0]      out_fill_count,
  output logic                  out_ok_seen,
  output logic                  out_error_seen,
  output logic                  out_overflow,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_index,
  input  wire logic [2:0]       cfg_data
);

  uartrx_pkg::ctrl_cmd_t cmd;
  logic                  cfg_we;

  // Register writes go straight into the length registers, so the port is ready whenever out of reset.
  assign cfg_ready = rst_n;
  assign cfg_we    = cfg_valid && cfg_ready;

  uartrx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  uartrx_dp #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .req_type   (in_req_type),
    .rx_byte    (in_rx_byte),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .read_data  (out_read_data),
    .read_valid (out_read_valid),
    .fill_count (out_fill_count),
    .ok_seen    (out_ok_seen),
    .error_seen (out_error_seen),
    .overflow   (out_overflow)
  );

endmodule

`default_nettype wire

// ===== sv/uartrx_checker.sv =====
`default_nettype none
`include "uart_rx_fifo_with_reply_match_top_assert.svh"

module uartrx_checker #(
  parameter int FIFO_DEPTH = uartrx_pkg::FIFO_DEPTH_DEF,
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1)
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [7:0]       out_read_data,
  input wire logic             out_read_valid,
  input wire logic [CNT_W-1:0] out_fill_count
);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

  // No result is left pending after reset.
  `URX_ASSERT_RST(a_rst_idle, clk, !rst_n |=> !out_valid, "result valid after reset")

  // A stalled result keeps its payload.
  `URX_ASSERT(a_hold, clk, rst_n,
              (out_valid && out_stall) |=>
              (out_valid && $stable(out_read_data) && $stable(out_fill_count)),
              "stalled result changed")

  // A newly accepted request never has its result out on the very next edge.
  `URX_ASSERT(a_lat, clk, rst_n, (in_valid && !in_stall) |=> !out_valid,
              "result appeared one cycle after request")

  // Read data is zero unless a byte was actually popped.
  `URX_ASSERT(a_rdata, clk, rst_n, (out_valid && !out_read_valid) |-> (out_read_data == 8'h00),
              "read data without a popped byte")

  // Fill level never exceeds the capacity.
  `URX_ASSERT(a_fill, clk, rst_n, out_valid |-> (out_fill_count <= CNT_FULL),
              "fill count beyond capacity")

endmodule

bind uart_rx_fifo_with_reply_match_top uartrx_checker #(
  .FIFO_DEPTH (FIFO_DEPTH)
) u_uartrx_checker (.*);

`default_nettype wire
